@@ hdl/turnout_state_tracker_macros.svh @@
// assertion macros for the turnout state tracker
// used by the top level only; needs nothing else
`ifndef TURNOUT_STATE_TRACKER_MACROS_SVH
`define TURNOUT_STATE_TRACKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tst_pkg.sv @@
// shared types, codes and constants of the turnout state tracker
// no dependencies; used by the interfaces and the top level
`default_nettype none

package tst_pkg;

    // table size and derived widths
    localparam int NUM_TURNOUTS = 2048;
    localparam int IDX_W        = $clog2(NUM_TURNOUTS);
    localparam int RX_IDX_W     = 11;
    localparam int NUM_W        = 12;
    localparam int STATE_W      = 2;
    localparam int OPCODE_W     = 8;
    localparam int BYTE_W       = 7;
    localparam int CMD_W        = 2;
    localparam int KIND_W       = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;

    // message bit positions in the second argument byte
    localparam int DIR_CLOSED_BIT = 5;
    localparam int OUTPUT_ON_BIT  = 4;

    // configuration reset values
    localparam logic                NOTIFY_RESET = 1'b0;
    localparam logic [OPCODE_W-1:0] OPCODE_RESET = 8'd176;

    // turnout state codes
    localparam logic [STATE_W-1:0] TS_UNKNOWN = 2'd0;
    localparam logic [STATE_W-1:0] TS_CLOSED  = 2'd1;
    localparam logic [STATE_W-1:0] TS_THROWN  = 2'd2;
    localparam logic [STATE_W-1:0] TS_INVALID = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_RX_MSG = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_THROW  = 2'd2,
        CMD_CLOSE  = 2'd3
    } cmd_e_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTICE = 2'd0,
        KIND_ANSWER = 2'd1,
        KIND_TX_MSG = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOTIFY_ENABLE  = 1'b0,
        REG_REQUEST_OPCODE = 1'b1
    } cfg_reg_e_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } fsm_e_t;

    // one result item
    typedef struct packed {
        kind_e_t              kind;
        logic [NUM_W-1:0]     turnout;
        logic [STATE_W-1:0]   turnout_state;
        logic [OPCODE_W-1:0]  tx_opcode;
        logic [BYTE_W-1:0]    tx_first_byte;
        logic [BYTE_W-1:0]    tx_second_byte;
        logic                 last;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/tst_if.sv @@
// valid/ready channel interfaces for command items and result items
// depends on tst_pkg for the field widths
`default_nettype none

interface tst_in_if;
    logic                             valid;
    logic                             ready;
    logic [tst_pkg::CMD_W-1:0]        command;
    logic [tst_pkg::NUM_W-1:0]        switch_number;
    logic [tst_pkg::OPCODE_W-1:0]     rx_opcode;
    logic [tst_pkg::BYTE_W-1:0]       rx_first_byte;
    logic [tst_pkg::BYTE_W-1:0]       rx_second_byte;

    modport source (output valid, command, switch_number, rx_opcode, rx_first_byte,
                    rx_second_byte, input ready);
    modport sink (input valid, command, switch_number, rx_opcode, rx_first_byte,
                  rx_second_byte, output ready);
endinterface

interface tst_out_if;
    logic                             valid;
    logic                             ready;
    logic [tst_pkg::KIND_W-1:0]       kind;
    logic [tst_pkg::NUM_W-1:0]        turnout;
    logic [tst_pkg::STATE_W-1:0]      turnout_state;
    logic [tst_pkg::OPCODE_W-1:0]     tx_opcode;
    logic [tst_pkg::BYTE_W-1:0]       tx_first_byte;
    logic [tst_pkg::BYTE_W-1:0]       tx_second_byte;
    logic                             last;

    modport source (output valid, kind, turnout, turnout_state, tx_opcode, tx_first_byte,
                    tx_second_byte, last, input ready);
    modport sink (input valid, kind, turnout, turnout_state, tx_opcode, tx_first_byte,
                  tx_second_byte, last, output ready);
endinterface

`default_nettype wire

@@ hdl/tst_ram.sv @@
// generic single-port ram with registered read data
// no dependencies
`default_nettype none

module tst_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/turnout_state_tracker.sv @@
// Turnout state tracker: keeps a 2-bit state for tst_pkg::NUM_TURNOUTS turnouts in one
// ram and encodes throw/close requests. After reset a clearing pass writes every
// entry to unknown, one per cycle; no item is accepted meanwhile, configuration writes
// are. Afterwards a query waits in a lookup state for the registered ram read, and a
// valid throw or close sends two results through the single output register, the
// second held in the emit state until that register is free. An item is accepted
// only while the output register is free or being emptied in that cycle.
// Depends on tst_pkg, tst_if, tst_ram and turnout_state_tracker_macros.svh.
`default_nettype none

`include "turnout_state_tracker_macros.svh"

module turnout_state_tracker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tst_in_if.sink                                 request,
    tst_out_if.source                              result,
    input  wire logic                              cfg_we,
    input  wire logic [tst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tst_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration
    logic                              notify_enable_reg;
    logic [tst_pkg::OPCODE_W-1:0]      request_opcode_reg;

    // control and holding state
    tst_pkg::fsm_e_t                   state_reg, state_next;
    logic [tst_pkg::IDX_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                              out_valid_reg, out_valid_next;
    tst_pkg::res_t                     out_reg, out_next;
    tst_pkg::res_t                     pend_reg, pend_next;
    logic                              look_ok_reg, look_ok_next;

    // ram port
    logic                              ram_we;
    logic [tst_pkg::IDX_W-1:0]         ram_addr;
    logic [tst_pkg::STATE_W-1:0]       ram_wdata;
    logic [tst_pkg::STATE_W-1:0]       ram_rdata;

    // decoded item fields
    tst_pkg::cmd_e_t                   cmd;
    logic [tst_pkg::RX_IDX_W-1:0]      rx_idx;
    logic                              rx_match;
    logic [tst_pkg::STATE_W-1:0]       rx_state;
    logic [tst_pkg::NUM_W-1:0]         num_m1;
    logic                              num_ok;
    logic                              closing;
    logic [tst_pkg::BYTE_W-1:0]        tx_b2;
    logic                              slot_free;
    logic                              accept;
    logic [tst_pkg::STATE_W-1:0]       look_state;

    tst_ram #(
        .WIDTH (tst_pkg::STATE_W),
        .DEPTH (tst_pkg::NUM_TURNOUTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notify_enable_reg  <= tst_pkg::NOTIFY_RESET;
            request_opcode_reg <= tst_pkg::OPCODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (tst_pkg::cfg_reg_e_t'(cfg_index))
                tst_pkg::REG_NOTIFY_ENABLE:  notify_enable_reg  <= cfg_data[0];
                tst_pkg::REG_REQUEST_OPCODE: request_opcode_reg <= cfg_data;
            endcase
        end
    end

    // item field decode
    assign cmd      = tst_pkg::cmd_e_t'(request.command);
    assign rx_idx   = {request.rx_second_byte[3:0], request.rx_first_byte};
    assign rx_match = (request.rx_opcode == request_opcode_reg)
                      && (tst_pkg::NUM_W'(rx_idx) < tst_pkg::NUM_W'(tst_pkg::NUM_TURNOUTS));
    assign rx_state = request.rx_second_byte[tst_pkg::DIR_CLOSED_BIT]
                      ? tst_pkg::TS_CLOSED : tst_pkg::TS_THROWN;
    assign num_m1   = request.switch_number - tst_pkg::NUM_W'(1);
    assign num_ok   = (request.switch_number != '0)
                      && (request.switch_number <= tst_pkg::NUM_W'(tst_pkg::NUM_TURNOUTS));
    assign closing  = (cmd == tst_pkg::CMD_CLOSE);
    assign tx_b2    = {1'b0, closing, 1'b0, num_m1[10:7]};

    // handshake
    assign slot_free     = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;
    assign request.ready = (state_reg == tst_pkg::ST_IDLE) && slot_free;

    // unwritten code three never occurs, but reads as unknown
    assign look_state = (look_ok_reg && ram_rdata != tst_pkg::TS_INVALID)
                        ? ram_rdata : tst_pkg::TS_UNKNOWN;

    // sequencer: next state, ram access and result loading
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_next       = out_reg;
        pend_next      = pend_reg;
        look_ok_next   = look_ok_reg;
        ram_we         = 1'b0;
        ram_addr       = rx_idx[tst_pkg::IDX_W-1:0];
        ram_wdata      = rx_state;

        unique case (state_reg)
            tst_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = tst_pkg::TS_UNKNOWN;
                clr_cnt_next = clr_cnt_reg + tst_pkg::IDX_W'(1);
                if (clr_cnt_reg == tst_pkg::IDX_W'(tst_pkg::NUM_TURNOUTS - 1))
                begin
                    state_next = tst_pkg::ST_IDLE;
                end
            end

            tst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        tst_pkg::CMD_RX_MSG:
                        begin
                            ram_we = rx_match;
                            if (rx_match && notify_enable_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_next       = '{kind: tst_pkg::KIND_NOTICE,
                                                   turnout: tst_pkg::NUM_W'(rx_idx)
                                                            + tst_pkg::NUM_W'(1),
                                                   turnout_state: rx_state,
                                                   tx_opcode: '0, tx_first_byte: '0,
                                                   tx_second_byte: '0, last: 1'b1};
                            end
                        end

                        tst_pkg::CMD_QUERY:
                        begin
                            ram_addr     = num_m1[tst_pkg::IDX_W-1:0];
                            look_ok_next = num_ok;
                            pend_next    = '{kind: tst_pkg::KIND_ANSWER,
                                             turnout: request.switch_number,
                                             turnout_state: tst_pkg::TS_UNKNOWN,
                                             tx_opcode: '0, tx_first_byte: '0,
                                             tx_second_byte: '0, last: 1'b1};
                            state_next   = tst_pkg::ST_LOOKUP;
                        end

                        tst_pkg::CMD_THROW, tst_pkg::CMD_CLOSE:
                        begin
                            out_valid_next = 1'b1;
                            if (!num_ok)
                            begin
                                out_next = '{kind: tst_pkg::KIND_ERROR,
                                             turnout: request.switch_number,
                                             turnout_state: tst_pkg::TS_UNKNOWN,
                                             tx_opcode: '0, tx_first_byte: '0,
                                             tx_second_byte: '0, last: 1'b1};
                            end
                            else
                            begin
                                // output-on now, output-off held in pend_reg for the emit state
                                pend_next = '{kind: tst_pkg::KIND_TX_MSG,
                                              turnout: request.switch_number,
                                              turnout_state: closing ? tst_pkg::TS_CLOSED
                                                                     : tst_pkg::TS_THROWN,
                                              tx_opcode: request_opcode_reg,
                                              tx_first_byte: num_m1[6:0],
                                              tx_second_byte: tx_b2, last: 1'b1};
                                out_next  = pend_next;
                                out_next.tx_second_byte[tst_pkg::OUTPUT_ON_BIT] = 1'b1;
                                out_next.last = 1'b0;
                                state_next = tst_pkg::ST_EMIT;
                            end
                        end
                    endcase
                end
            end

            tst_pkg::ST_LOOKUP:
            begin
                // output register was free or being emptied at accept and nothing was loaded since
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_next.turnout_state = look_state;
                state_next     = tst_pkg::ST_IDLE;
            end

            tst_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    state_next     = tst_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tst_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        pend_reg    <= pend_next;
        look_ok_reg <= look_ok_next;
    end

    // result channel
    assign result.valid          = out_valid_reg;
    assign result.kind           = out_reg.kind;
    assign result.turnout        = out_reg.turnout;
    assign result.turnout_state  = out_reg.turnout_state;
    assign result.tx_opcode      = out_reg.tx_opcode;
    assign result.tx_first_byte  = out_reg.tx_first_byte;
    assign result.tx_second_byte = out_reg.tx_second_byte;
    assign result.last           = out_reg.last;

    // checks
    `TST_ASSERT_IMP(a_clear_quiet, clk, rst_n, state_reg == tst_pkg::ST_CLEAR,
        !out_valid_reg && !request.ready, "item activity during clearing pass")
    `TST_ASSERT_IMP(a_lookup_slot, clk, rst_n, state_reg == tst_pkg::ST_LOOKUP,
        !out_valid_reg, "output register busy when query answer arrives")
    `TST_ASSERT_IMP(a_emit_first, clk, rst_n, state_reg == tst_pkg::ST_EMIT,
        out_valid_reg && !out_reg.last && pend_reg.last, "request pair out of order")
    `TST_ASSERT_NXT(a_query_lookup, clk, rst_n,
        accept && cmd == tst_pkg::CMD_QUERY, state_reg == tst_pkg::ST_LOOKUP,
        "query did not enter lookup")

endmodule

`default_nettype wire
